// ===== hdl/shamh_pkg.sv =====
// shared types, commands and constants of the sha-256 message hasher
package shamh_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_FINAL,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		SEL_DATA,
		SEL_SHORT,
		SEL_PAD,
		SEL_ZERO,
		SEL_LEN_HI,
		SEL_LEN_LO
	} word_sel_t;

	typedef struct packed {
		logic      push;
		word_sel_t sel;
		logic      add_len;
		logic      round_en;
		logic [5:0] round;
		logic      chain_add;
		logic      emit;
	} cmd_t;

	typedef struct packed {
		logic idx_14;
		logic idx_15;
	} status_t;

	localparam logic [31:0] PAD_WORD = 32'h8000_0000;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

// ===== hdl/shamh_ctrl.sv =====
// controller state machine: word intake, padding sequence, rounds, digest hand-off
module shamh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        byte_count,
	input  logic              last_word,
	output logic              out_valid,
	input  logic              out_ready,
	input  shamh_pkg::status_t status,
	output shamh_pkg::cmd_t    cmd
);

	shamh_pkg::state_t state_q, state_d;
	logic [5:0] round_q, round_d;
	logic       msg_end_q, msg_end_d;
	logic       pad_pend_q, pad_pend_d;
	logic       len_hi_q, len_hi_d;
	logic       done_q, done_d;
	logic       out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= shamh_pkg::ST_IDLE;
			round_q     <= '0;
			msg_end_q   <= 1'b0;
			pad_pend_q  <= 1'b0;
			len_hi_q    <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			round_q     <= round_d;
			msg_end_q   <= msg_end_d;
			pad_pend_q  <= pad_pend_d;
			len_hi_q    <= len_hi_d;
			done_q      <= done_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		round_d    = round_q;
		msg_end_d  = msg_end_q;
		pad_pend_d = pad_pend_q;
		len_hi_d   = len_hi_q;
		done_d     = done_q;
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.sel    = shamh_pkg::SEL_ZERO;
		cmd.round  = round_q;
		case (state_q)
			shamh_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.push    = 1'b1;
					cmd.add_len = 1'b1;
					if (!last_word) begin
						cmd.sel = shamh_pkg::SEL_DATA;
						if (status.idx_15)
							state_d = shamh_pkg::ST_COMP;
					end else begin
						msg_end_d = 1'b1;
						// a full last word goes in as is, the pad word follows
						if (byte_count > 3'd3) begin
							cmd.sel    = shamh_pkg::SEL_DATA;
							pad_pend_d = 1'b1;
						end else begin
							cmd.sel = shamh_pkg::SEL_SHORT;
						end
						state_d = status.idx_15 ? shamh_pkg::ST_COMP : shamh_pkg::ST_PAD;
					end
				end
			end
			shamh_pkg::ST_PAD: begin
				cmd.push = 1'b1;
				if (pad_pend_q) begin
					cmd.sel    = shamh_pkg::SEL_PAD;
					pad_pend_d = 1'b0;
				end else if (len_hi_q && status.idx_15) begin
					cmd.sel = shamh_pkg::SEL_LEN_LO;
					done_d  = 1'b1;
				end else if (status.idx_14) begin
					cmd.sel  = shamh_pkg::SEL_LEN_HI;
					len_hi_d = 1'b1;
				end else begin
					cmd.sel = shamh_pkg::SEL_ZERO;
				end
				if (status.idx_15)
					state_d = shamh_pkg::ST_COMP;
			end
			shamh_pkg::ST_COMP: begin
				cmd.round_en = 1'b1;
				round_d = round_q + 6'd1;
				if (round_q == 6'd63)
					state_d = shamh_pkg::ST_FINAL;
			end
			shamh_pkg::ST_FINAL: begin
				cmd.chain_add = 1'b1;
				if (done_q)
					state_d = shamh_pkg::ST_EMIT;
				else if (msg_end_q)
					state_d = shamh_pkg::ST_PAD;
				else
					state_d = shamh_pkg::ST_IDLE;
			end
			shamh_pkg::ST_EMIT: begin
				// wait for the output register to be free
				if (!out_valid_q || out_ready) begin
					cmd.emit   = 1'b1;
					msg_end_d  = 1'b0;
					pad_pend_d = 1'b0;
					len_hi_d   = 1'b0;
					done_d     = 1'b0;
					state_d    = shamh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = shamh_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (cmd.emit)
			out_valid_d = 1'b1;
		else if (out_ready)
			out_valid_d = 1'b0;
		else
			out_valid_d = out_valid_q;
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/shamh_dp.sv =====
// datapath: schedule window, round variables, chain words, length and digest register
module shamh_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [31:0]       data_word,
	input  logic [2:0]        byte_count,
	input  logic              last_word,
	input  shamh_pkg::cmd_t    cmd,
	output shamh_pkg::status_t status,
	output logic [31:0]       digest [8]
);

	logic [3:0]  word_idx_q;
	logic [60:0] len_q;
	logic [31:0] chain_q [8];
	logic [31:0] sched_q [16];
	logic [31:0] var_q [8];
	logic [31:0] digest_q [8];

	logic [31:0] push_word;
	logic [31:0] short_word;
	logic [60:0] len_inc;
	logic [31:0] big0, big1, choose, major, t1, t2;
	logic [31:0] sig0, sig1, sched_new;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	// last word with fewer than four bytes: keep leading bytes, then the pad byte
	always_comb begin
		case (byte_count)
			3'd1:    short_word = {data_word[31:24], shamh_pkg::PAD_BYTE, 16'h0000};
			3'd2:    short_word = {data_word[31:16], shamh_pkg::PAD_BYTE, 8'h00};
			3'd3:    short_word = {data_word[31:8], shamh_pkg::PAD_BYTE};
			default: short_word = shamh_pkg::PAD_WORD;
		endcase
	end

	always_comb begin
		case (cmd.sel)
			shamh_pkg::SEL_DATA:   push_word = data_word;
			shamh_pkg::SEL_SHORT:  push_word = short_word;
			shamh_pkg::SEL_PAD:    push_word = shamh_pkg::PAD_WORD;
			shamh_pkg::SEL_LEN_HI: push_word = len_q[60:29];
			shamh_pkg::SEL_LEN_LO: push_word = {len_q[28:0], 3'b000};
			default:               push_word = '0;
		endcase
	end

	always_comb begin
		if (last_word && !byte_count[2])
			len_inc = {58'd0, byte_count};
		else
			len_inc = 61'd4;
	end

	// one round of compression and the next schedule word
	always_comb begin
		big1   = rotr(var_q[4], 6) ^ rotr(var_q[4], 11) ^ rotr(var_q[4], 25);
		choose = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
		t1     = var_q[7] + big1 + choose + shamh_pkg::ROUND_K[cmd.round] + sched_q[0];
		big0   = rotr(var_q[0], 2) ^ rotr(var_q[0], 13) ^ rotr(var_q[0], 22);
		major  = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
		t2     = big0 + major;
		sig0   = rotr(sched_q[1], 7) ^ rotr(sched_q[1], 18) ^ (sched_q[1] >> 3);
		sig1   = rotr(sched_q[14], 17) ^ rotr(sched_q[14], 19) ^ (sched_q[14] >> 10);
		sched_new = sched_q[0] + sig0 + sched_q[9] + sig1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_idx_q <= '0;
			len_q      <= '0;
			for (int i = 0; i < 8; i++)
				chain_q[i] <= shamh_pkg::INIT_H[i];
		end else begin
			if (cmd.push)
				word_idx_q <= word_idx_q + 4'd1;
			if (cmd.emit) begin
				len_q <= '0;
			end else if (cmd.add_len) begin
				len_q <= len_q + len_inc;
			end
			if (cmd.emit) begin
				for (int i = 0; i < 8; i++)
					chain_q[i] <= shamh_pkg::INIT_H[i];
			end else if (cmd.chain_add) begin
				for (int i = 0; i < 8; i++)
					chain_q[i] <= chain_q[i] + var_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			for (int i = 0; i < 15; i++)
				sched_q[i] <= sched_q[i + 1];
			sched_q[15] <= push_word;
			// sixteenth word: start a block from the chain
			if (word_idx_q == 4'd15) begin
				for (int i = 0; i < 8; i++)
					var_q[i] <= chain_q[i];
			end
		end else if (cmd.round_en) begin
			for (int i = 0; i < 15; i++)
				sched_q[i] <= sched_q[i + 1];
			sched_q[15] <= sched_new;
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
		if (cmd.emit) begin
			for (int i = 0; i < 8; i++)
				digest_q[i] <= chain_q[i];
		end
	end

	assign status.idx_14 = (word_idx_q == 4'd14);
	assign status.idx_15 = (word_idx_q == 4'd15);
	assign digest = digest_q;

endmodule

// ===== hdl/sha256_message_hasher_top.sv =====
// top level of the streaming sha-256 message hasher
// a word that does not fill a block is taken while the hasher is idle; the sixteenth word
// of a block starts the compression rounds of that block, followed by a chain add
// after the last word, padding pushes one fill word per cycle and compresses each full block,
// then loads the digest register once the output register is free
// asynchronous reset restores the initial hash words and clears length and index
module sha256_message_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word_0,
	output logic [31:0] digest_word_1,
	output logic [31:0] digest_word_2,
	output logic [31:0] digest_word_3,
	output logic [31:0] digest_word_4,
	output logic [31:0] digest_word_5,
	output logic [31:0] digest_word_6,
	output logic [31:0] digest_word_7
);

	shamh_pkg::cmd_t    cmd;
	shamh_pkg::status_t status;
	logic [31:0]        digest [8];

	shamh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_count (byte_count),
		.last_word  (last_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.cmd        (cmd)
	);

	shamh_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last_word  (last_word),
		.cmd        (cmd),
		.status     (status),
		.digest     (digest)
	);

	assign digest_word_0 = digest[0];
	assign digest_word_1 = digest[1];
	assign digest_word_2 = digest[2];
	assign digest_word_3 = digest[3];
	assign digest_word_4 = digest[4];
	assign digest_word_5 = digest[5];
	assign digest_word_6 = digest[6];
	assign digest_word_7 = digest[7];

endmodule

// ===== hdl/shamh_checker.sv =====
// port-level checks of the hasher and their binding to the top level
module shamh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        last_word,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word_0
);

	// a waiting digest stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word_0))
		else $error("digest changed or dropped while stalled");

	// a last word always leaves padding or rounds to do
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_word |=> !in_ready)
		else $error("input taken right after a last word");

	// a digest is only loaded while no word can be taken
	a_emit_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("digest appeared while the input side was open");

endmodule

bind sha256_message_hasher_top shamh_checker u_shamh_checker (.*);

// ===== bench/sha256_message_hasher_top_tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for the streaming sha-256 message hasher: known digests, random messages
module sha256_message_hasher_top_tb;

	localparam int CLK_PERIOD   = 12;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_CYCLES  = 500;
	localparam int PHASE_WORDS  = 480;
	localparam int SEND_IDLE [4] = '{0, 79, 0, 25};
	localparam int RECV_STALL [4] = '{0, 0, 79, 25};

	typedef logic [0:7][31:0] digest_t;

	typedef struct {
		logic [31:0] data;
		logic [2:0]  cnt;
		logic        fin;
		bit          known;
		digest_t     sum;
	} vec_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] data_word = '0;
	logic [2:0]  byte_count = '0;
	logic        last_word = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word_0, digest_word_1, digest_word_2, digest_word_3;
	logic [31:0] digest_word_4, digest_word_5, digest_word_6, digest_word_7;

	// predictor state
	logic [31:0] chain_h [8];
	logic [31:0] blk_w [16];
	logic [3:0]  blk_fill;
	logic [60:0] msg_len;

	digest_t     pending_digests [$];
	int unsigned n_errors = 0;
	int unsigned n_words = 0;
	int unsigned n_digests = 0;
	int unsigned quiet_cycles = 0;
	int unsigned hold_left = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_req = 1'b0;
	bit          hold_seen = 1'b0;

	// typed digests: empty message and "abc"
	vec_row_t vec_tab [14] = '{
		'{32'h0000_0000, 3'd0, 1'b1, 1'b1, 256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855},
		'{32'h6162_6300, 3'd3, 1'b1, 1'b1, 256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad},
		'{32'hffff_ffff, 3'd4, 1'b1, 1'b0, '0},
		'{32'h0000_0000, 3'd4, 1'b1, 1'b0, '0},
		'{32'h1234_5678, 3'd7, 1'b1, 1'b0, '0},
		'{32'h89ab_cdef, 3'd5, 1'b1, 1'b0, '0},
		'{32'hdead_beef, 3'd1, 1'b0, 1'b0, '0},
		'{32'hcafe_f00d, 3'd0, 1'b0, 1'b0, '0},
		'{32'ha5a5_a5a5, 3'd6, 1'b0, 1'b0, '0},
		'{32'h5a5a_5a5a, 3'd2, 1'b1, 1'b0, '0},
		'{32'hffff_ffff, 3'd1, 1'b1, 1'b0, '0},
		'{32'hffff_ffff, 3'd3, 1'b1, 1'b0, '0},
		'{32'h0102_0304, 3'd4, 1'b0, 1'b0, '0},
		'{32'hffff_ffff, 3'd0, 1'b1, 1'b0, '0}
	};

	sha256_message_hasher_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_word(data_word),
		.byte_count(byte_count),
		.last_word(last_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.digest_word_0(digest_word_0),
		.digest_word_1(digest_word_1),
		.digest_word_2(digest_word_2),
		.digest_word_3(digest_word_3),
		.digest_word_4(digest_word_4),
		.digest_word_5(digest_word_5),
		.digest_word_6(digest_word_6),
		.digest_word_7(digest_word_7)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void sha_restart();
		for (int i = 0; i < 8; i++)
			chain_h[i] = shamh_pkg::INIT_H[i];
		blk_fill = '0;
		msg_len = '0;
	endfunction

	function automatic void sha_compress();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = blk_w[i];
		for (int i = 16; i < 64; i++) begin
			s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
		e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ shamh_pkg::ROUND_K[i] + w[i];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
		chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
	endfunction

	function automatic void load_block_word(input logic [31:0] w);
		blk_w[blk_fill] = w;
		blk_fill++;
		if (blk_fill == 0)
			sha_compress();
	endfunction

	// absorbs one message word; returns 1 with the digest when the word ends a message
	function automatic bit sha_absorb_word(input logic [31:0] d, input logic [2:0] c,
		input logic l, output digest_t dg);
		logic [63:0] bit_len;
		int n;
		dg = '0;
		if (!l) begin
			msg_len += 61'd4;
			load_block_word(d);
			return 1'b0;
		end
		n = (c > 3'd4) ? 4 : int'(c);
		msg_len += 61'(n);
		if (n == 4) begin
			load_block_word(d);
			load_block_word(shamh_pkg::PAD_WORD);
		end else if (n == 0) begin
			load_block_word(shamh_pkg::PAD_WORD);
		end else begin
			load_block_word((d & (32'hffff_ffff << (32 - 8 * n)))
				| (32'(shamh_pkg::PAD_BYTE) << (24 - 8 * n)));
		end
		// length does not fit behind the pad: close this block with zeros
		if (blk_fill > 4'd14 || blk_fill == 4'd0) begin
			while (blk_fill != 4'd0)
				load_block_word('0);
		end
		while (blk_fill < 4'd14)
			load_block_word('0);
		bit_len = {msg_len, 3'b000};
		load_block_word(bit_len[63:32]);
		load_block_word(bit_len[31:0]);
		for (int k = 0; k < 8; k++)
			dg[k] = chain_h[k];
		sha_restart();
		return 1'b1;
	endfunction

	function automatic logic [31:0] rand_data();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// words ahead of the last one; lengths near 14 mod 16 force the extra pad block
	function automatic int unsigned pick_len();
		case ($urandom_range(9))
			0, 1: return $urandom_range(3);
			2, 3: return 13 + $urandom_range(4);
			4: return 29 + $urandom_range(4);
			5: return $urandom_range(100, 64);
			default: return $urandom_range(30);
		endcase
	endfunction

	task automatic send_word(input logic [31:0] d, input logic [2:0] c, input logic l,
		input bit known, input digest_t sum);
		digest_t pred;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		data_word <= d;
		byte_count <= c;
		last_word <= l;
		do @(posedge clk); while (!in_ready);
		n_words++;
		if (sha_absorb_word(d, c, l, pred))
			pending_digests.push_back(known ? sum : pred);
	endtask

	task automatic send_message(input int unsigned nw);
		for (int i = 0; i < nw; i++)
			send_word(rand_data(), 3'($urandom_range(7)), 1'b0, 1'b0, '0);
		send_word(rand_data(), 3'($urandom_range(7)), 1'b1, 1'b0, '0);
	endtask

	// digest check and output-side backpressure
	always @(posedge clk) begin
		digest_t got, want;
		got = {digest_word_0, digest_word_1, digest_word_2, digest_word_3,
			digest_word_4, digest_word_5, digest_word_6, digest_word_7};
		if (arst_n && out_valid && out_ready) begin
			n_digests++;
			if (pending_digests.size() == 0) begin
				n_errors++;
				$display("%0t digest with no message pending: expected none, got %h", $time, got);
			end else begin
				want = pending_digests.pop_front();
				for (int k = 0; k < 8; k++) begin
					if (got[k] !== want[k]) begin
						n_errors++;
						$display("%0t digest_word_%0d expected %08h got %08h",
							$time, k, want[k], got[k]);
					end
				end
			end
		end
		if (hold_req && !hold_seen) begin
			hold_seen = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("sha256_message_hasher_top_tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned phase_start;
		sha_restart();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (vec_tab[r])
			send_word(vec_tab[r].data, vec_tab[r].cnt, vec_tab[r].fin, vec_tab[r].known,
				vec_tab[r].sum);
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = SEND_IDLE[p];
			recv_stall_pct = RECV_STALL[p];
			// long output hold while words keep coming, so the input backs up
			if (p == 0)
				hold_req = 1'b1;
			phase_start = n_words;
			while (n_words - phase_start < PHASE_WORDS)
				send_message(pick_len());
		end
		in_valid <= 1'b0;
		while (pending_digests.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("hashed %0d words into %0d digests, with known vectors, short last words",
			n_words, n_digests);
		$display("and pad overflow, across idle, stall, mixed and long-hold phases");
		if (n_errors == 0)
			$display("sha256_message_hasher_top_tb: clean");
		else
			$display("sha256_message_hasher_top_tb: errors");
		$finish;
	end

endmodule
